### hw/rtl/tcw_pkg.sv
// Package for the text console character writer.
// Holds the shared types, character codes and register indexes.
// Used by tcw_front, tcw_back and text_console_char_writer_unit.
package tcw_pkg;

  // Default screen size
  localparam int unsigned TCW_COLUMNS = 80;
  localparam int unsigned TCW_ROWS    = 25;

  // Depth of the queues between front, back and result port
  localparam int unsigned TCW_QUEUE_DEPTH = 2;

  // Field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned INDEX_W = 16;
  localparam int unsigned COLOR_W = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Request types
  localparam logic REQ_DRAW = 1'b0;
  localparam logic REQ_POS  = 1'b1;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd1;

  // Character class found by the front
  typedef enum logic [2:0] {
    CLS_PRINT,
    CLS_NEWLINE,
    CLS_RETURN,
    CLS_BACKSPACE,
    CLS_OTHER
  } cls_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic                is_pos;
    cls_t                cls;
    logic [CHAR_W-1:0]   char_code;
    logic [POS_W-1:0]    pos_col;
    logic [POS_W-1:0]    pos_row;
    logic [INDEX_W-1:0]  pos_index;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic                cell_write;
    logic [INDEX_W-1:0]  cell_addr;
    logic [INDEX_W-1:0]  cell_data;
    logic                cursor_update;
    logic [INDEX_W-1:0]  cursor_location;
    logic [INDEX_W-1:0]  row_now;
  } result_t;

endpackage

### hw/rtl/text_console_char_writer_unit.sv
// Top level of the text console character writer.
// Depends on tcw_pkg, tcw_front, tcw_fifo and tcw_back.
//
//   channel  direction  handshake              payload
//   in_      input      in_push / in_full      req_type, char_code, row_req, col_req
//   out_     output     out_empty / out_pop    cell_write, cell_addr, cell_data,
//                                              cursor_update, cursor_location, row_now
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while the out_ side keeps popping results; the back
// computes each cursor update combinationally. An item's result reaches the out_
// ports through the command queue, then the result queue. Reset is synchronous and
// clears cursor, colors and both queues. A stalled result fills the result queue,
// then the command queue, then raises in_full. Configuration writes are always
// taken (cfg_ready is high).
module text_console_char_writer_unit
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = TCW_COLUMNS,
  parameter int unsigned ROWS    = TCW_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_req_type,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic [POS_W-1:0]      in_row_req,
  input  logic [POS_W-1:0]      in_col_req,
  // Result channel
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic                  out_cell_write,
  output logic [INDEX_W-1:0]    out_cell_addr,
  output logic [INDEX_W-1:0]    out_cell_data,
  output logic                  out_cursor_update,
  output logic [INDEX_W-1:0]    out_cursor_location,
  output logic [INDEX_W-1:0]    out_row_now,
  // Configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [COLOR_W-1:0] fg_r, bg_r;
  cmd_t               front_cmd, back_cmd;
  logic               cmd_empty, cmd_pop;
  logic               res_full, res_push;
  result_t            back_res, out_res;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= '0;
      bg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FOREGROUND: fg_r <= cfg_data[COLOR_W-1:0];
        CFG_BACKGROUND: bg_r <= cfg_data[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .req_type  (in_req_type),
    .char_code (in_char_code),
    .row_req   (in_row_req),
    .col_req   (in_col_req),
    .cmd       (front_cmd)
  );

  tcw_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (TCW_QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_cmd),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (back_cmd),
    .empty (cmd_empty)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .attr      ({bg_r, fg_r}),
    .cmd       (back_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  tcw_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (TCW_QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_res),
    .empty (out_empty)
  );

  // Unpack the oldest result onto the ports
  assign out_cell_write      = out_res.cell_write;
  assign out_cell_addr       = out_res.cell_addr;
  assign out_cell_data       = out_res.cell_data;
  assign out_cursor_update   = out_res.cursor_update;
  assign out_cursor_location = out_res.cursor_location;
  assign out_row_now         = out_res.row_now;

endmodule

### hw/rtl/tcw_fifo.sv
// Small synchronous queue built from a register array.
// Used between front and back and in front of the result port.
// Standalone: no package dependency.
module tcw_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push & ~full;
  assign pop_ok  = pop & ~empty;
  assign rdata   = entry_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed data
  always_ff @(posedge clk) begin
    if (push_ok) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### hw/rtl/tcw_front.sv
// Front of the console writer: classifies a character or resolves a position.
// Depends on tcw_pkg for cmd_t, cls_t and the character codes.
// Position items are fully resolved here, as they need no cursor state.
module tcw_front
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = TCW_COLUMNS,
  parameter int unsigned ROWS    = TCW_ROWS
) (
  input  logic              req_type,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [POS_W-1:0]  row_req,
  input  logic [POS_W-1:0]  col_req,
  output cmd_t              cmd
);

  localparam logic [POS_W-1:0] COLS_C = POS_W'(COLUMNS);
  localparam logic [POS_W-1:0] ROWS_C = POS_W'(ROWS);

  logic [POS_W-1:0] col_cap, row_cap;

  // Cap the requested position at the screen size
  assign col_cap = (col_req >= COLS_C) ? COLS_C : col_req;
  assign row_cap = (row_req >= ROWS_C) ? ROWS_C : row_req;

  always_comb begin
    cmd.is_pos    = (req_type == REQ_POS);
    cmd.char_code = char_code;
    cmd.pos_col   = col_cap;
    cmd.pos_row   = row_cap;
    // Linear index of the position; fits 16 bits for 8-bit row and column
    cmd.pos_index = INDEX_W'({8'd0, row_cap} * {8'd0, COLS_C}) + INDEX_W'(col_cap);
    // Classify the character
    if (char_code >= CH_SPACE) begin
      cmd.cls = CLS_PRINT;
    end else begin
      unique case (char_code)
        CH_NEWLINE:   cmd.cls = CLS_NEWLINE;
        CH_RETURN:    cmd.cls = CLS_RETURN;
        CH_BACKSPACE: cmd.cls = CLS_BACKSPACE;
        default:      cmd.cls = CLS_OTHER;
      endcase
    end
  end

endmodule

### hw/rtl/tcw_back.sv
// Back of the console writer: holds the cursor and carries out commands.
// Depends on tcw_pkg for cmd_t, result_t and the class codes.
// Takes one command per cycle while the result queue has room.
module tcw_back
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = TCW_COLUMNS,
  parameter int unsigned ROWS    = TCW_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        attr,
  input  cmd_t              cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output result_t           res
);

  localparam logic [POS_W-1:0]   COLS_C  = POS_W'(COLUMNS);
  localparam logic [INDEX_W-1:0] COLS_16 = INDEX_W'(COLUMNS);
  localparam logic [INDEX_W-1:0] ROWS_16 = INDEX_W'(ROWS);

  logic [POS_W-1:0]   column_r, column_nxt;
  logic [INDEX_W-1:0] line_r, line_nxt;
  logic [INDEX_W-1:0] index_r, index_nxt;
  logic [POS_W-1:0]   col_w;
  logic [INDEX_W-1:0] line_w;

  assign cmd_pop  = ~cmd_empty & ~res_full;
  assign res_push = cmd_pop;

  // Execute one command against the cursor
  always_comb begin
    column_nxt = column_r;
    line_nxt   = line_r;
    index_nxt  = index_r;
    res        = '0;
    // Wrap the column once it has reached the width
    if (column_r >= COLS_C) begin
      col_w  = '0;
      line_w = line_r + 1'b1;
    end else begin
      col_w  = column_r;
      line_w = line_r;
    end
    if (cmd.is_pos) begin
      column_nxt = cmd.pos_col;
      line_nxt   = INDEX_W'(cmd.pos_row);
      index_nxt  = cmd.pos_index;
    end else begin
      column_nxt = col_w;
      line_nxt   = line_w;
      case (cmd.cls)
        CLS_PRINT: begin
          res.cell_write = 1'b1;
          res.cell_addr  = index_r;
          res.cell_data  = {attr, cmd.char_code};
          index_nxt      = index_r + 1'b1;
          column_nxt     = col_w + 1'b1;
        end
        CLS_NEWLINE: begin
          index_nxt  = index_r + COLS_16 - INDEX_W'(col_w);
          column_nxt = '0;
          line_nxt   = line_w + 1'b1;
        end
        CLS_RETURN: begin
          index_nxt  = index_r - INDEX_W'(col_w);
          column_nxt = '0;
        end
        CLS_BACKSPACE: begin
          if (col_w != '0) begin
            index_nxt  = index_r - 1'b1;
            column_nxt = col_w - 1'b1;
          end
        end
        default: begin
        end
      endcase
      res.cursor_update   = 1'b1;
      res.cursor_location = index_nxt;
    end
    res.row_now = line_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      line_r   <= '0;
      index_r  <= '0;
    end else if (cmd_pop) begin
      column_r <= column_nxt;
      line_r   <= line_nxt;
      index_r  <= index_nxt;
    end
  end

  // A cell write always comes with a cursor write
  a_write_has_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res.cell_write |-> res.cursor_update)
    else $error("cell write without cursor update");

  // The column never passes the width
  a_column_bound: assert property (@(posedge clk) disable iff (!rst_n)
    column_r <= COLS_C)
    else $error("column beyond width");

  // A printed character leaves the cursor off column zero
  a_print_advances: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop && !cmd.is_pos && cmd.cls == CLS_PRINT |=> column_r != '0)
    else $error("print did not advance column");

  // A position command leaves the row capped
  a_pos_row_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop && cmd.is_pos |=> line_r <= ROWS_16)
    else $error("position row not capped");

endmodule
